/* design/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// cond must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

/* design/rslc_pkg.sv */
package rslc_pkg;

   localparam int COORD_W     = 32;
   localparam int BOUND_W     = 16;
   localparam int CSR_INDEX_W = 3;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [BOUND_W-1:0] bound_type;
   typedef logic [3:0]                outcode_type;
   typedef logic [1:0]                kind_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct packed {
      bound_type left_bound;
      bound_type right_bound;
      bound_type bottom_bound;
      bound_type top_bound;
   } bounds_type;

   localparam outcode_type OC_TOP    = 4'h1;
   localparam outcode_type OC_BOTTOM = 4'h2;
   localparam outcode_type OC_RIGHT  = 4'h4;
   localparam outcode_type OC_LEFT   = 4'h8;

   localparam kind_type KIND_VERT    = 2'd0;
   localparam kind_type KIND_HORIZ   = 2'd1;
   localparam kind_type KIND_SLOPE   = 2'd2;
   localparam kind_type KIND_INVALID = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_LEFT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOTTOM = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOP    = 3'd3;

endpackage

/* design/rslc_csr_regs.sv */
module rslc_csr_regs (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rslc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rslc_pkg::BOUND_W-1:0]       csr_data,
   output rslc_pkg::bounds_type               bounds
);
   import rslc_pkg::*;

   bounds_type bounds_ff, bounds_in;

   assign csr_ready = 1'b1;
   assign bounds    = bounds_ff;

   always_comb begin
      bounds_in = bounds_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LEFT:   bounds_in.left_bound   = bound_type'(csr_data);
            CSR_RIGHT:  bounds_in.right_bound  = bound_type'(csr_data);
            CSR_BOTTOM: bounds_in.bottom_bound = bound_type'(csr_data);
            CSR_TOP:    bounds_in.top_bound    = bound_type'(csr_data);
            default:    bounds_in = bounds_ff; // unmapped index, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bounds_ff.left_bound   <= bound_type'(0);
         bounds_ff.right_bound  <= bound_type'(255);
         bounds_ff.bottom_bound <= bound_type'(0);
         bounds_ff.top_bound    <= bound_type'(255);
      end else begin
         bounds_ff <= bounds_in;
      end
   end

endmodule

/* design/rslc_clip_alu.sv */
module rslc_clip_alu #(
   parameter int SLOPE_SHIFT = 1
) (
   input  rslc_pkg::kind_type    kind,
   input  rslc_pkg::outcode_type code,
   input  rslc_pkg::point_type   pt,
   input  rslc_pkg::point_type   other,
   input  rslc_pkg::bounds_type  bounds,
   output rslc_pkg::point_type   clip_pt,
   output rslc_pkg::outcode_type pt_code
);
   import rslc_pkg::*;

   coord_type lb, rb, bb, tb;
   coord_type px, py, ox, oy;
   coord_type dist_a, dist_b, gap, step_amt;
   logic      y_side;

   always_comb begin
      lb = coord_type'(bounds.left_bound);
      rb = coord_type'(bounds.right_bound);
      bb = coord_type'(bounds.bottom_bound);
      tb = coord_type'(bounds.top_bound);
      px = pt.x;
      py = pt.y;
      ox = other.x;
      oy = other.y;

      // outcode of the presented point
      pt_code = '0;
      if (py > tb) begin
         pt_code = pt_code | OC_TOP;
      end else if (py < bb) begin
         pt_code = pt_code | OC_BOTTOM;
      end
      if (px > rb) begin
         pt_code = pt_code | OC_RIGHT;
      end else if (px < lb) begin
         pt_code = pt_code | OC_LEFT;
      end

      // one subtractor: distance past the crossed edge (never negative)
      y_side = (code & (OC_TOP | OC_BOTTOM)) != '0;
      if ((code & OC_TOP) != '0) begin
         dist_a = py;
         dist_b = tb;
      end else if ((code & OC_BOTTOM) != '0) begin
         dist_a = bb;
         dist_b = py;
      end else if ((code & OC_RIGHT) != '0) begin
         dist_a = px;
         dist_b = rb;
      end else begin
         dist_a = lb;
         dist_b = px;
      end
      gap      = dist_a - dist_b;
      step_amt = y_side ? (gap <<< SLOPE_SHIFT) : (gap >>> SLOPE_SHIFT);

      clip_pt = pt;
      case (kind)
         KIND_VERT: begin
            clip_pt.y = ((code & OC_TOP) != '0) ? tb : bb;
         end
         KIND_HORIZ: begin
            clip_pt.x = ((code & OC_RIGHT) != '0) ? rb : lb;
         end
         default: begin
            if (y_side) begin
               clip_pt.x = (px < ox) ? px + step_amt : px - step_amt;
               clip_pt.y = ((code & OC_TOP) != '0) ? tb : bb;
            end else begin
               clip_pt.y = (py < oy) ? py + step_amt : py - step_amt;
               clip_pt.x = ((code & OC_RIGHT) != '0) ? rb : lb;
            end
         end
      endcase
   end

endmodule

/* design/restricted_slope_line_clipper.sv */
// After a req transaction the sequencer codes both ends and tests, then takes k clip steps
// (0..MAX_CLIP_STEPS); each step is clip, recode, test on one shared ALU.
// A new segment is taken only while the sequencer is idle; an invalid kind is dropped.
// The result register frees the sequencer while a result waits to be taken.
// Reset (synchronous, active high) idles the sequencer, drops any pending
// result and restores the clip rectangle to 0..255 on both axes.
`include "assert_macros.svh"

module restricted_slope_line_clipper #(
   parameter int SLOPE_SHIFT    = 1,
   parameter int MAX_CLIP_STEPS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // start_x, start_y, end_x, end_y, offset_x, offset_y
   input  logic [63:0]                      req_tdata,
   // line_kind
   input  logic [1:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // pen_y, pen_x, delta_y, delta_x
   output logic [31:0]                      rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rslc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rslc_pkg::BOUND_W-1:0]     csr_data
);
   import rslc_pkg::*;

   localparam int STEP_W = $clog2(MAX_CLIP_STEPS + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CODE0  = 3'd1;
   localparam logic [2:0] ST_CODE1  = 3'd2;
   localparam logic [2:0] ST_TEST   = 3'd3;
   localparam logic [2:0] ST_CLIP   = 3'd4;
   localparam logic [2:0] ST_RECODE = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              sel_ff, sel_in;
   kind_type          kind_ff, kind_in;
   point_type         p0_ff, p0_in, p1_ff, p1_in;
   outcode_type       c0_ff, c0_in, c1_ff, c1_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;

   bounds_type        bounds;
   point_type         alu_pt, alu_other, clip_pt;
   outcode_type       alu_code, pt_code;
   logic              rsp_free;

   logic signed [7:0]  in_sx, in_sy, in_ex, in_ey;
   logic signed [15:0] in_ox, in_oy;
   logic [7:0]         pen_y, pen_x, delta_y, delta_x;

   rslc_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .bounds    (bounds)
   );

   rslc_clip_alu #(
      .SLOPE_SHIFT (SLOPE_SHIFT)
   ) u_alu (
      .kind    (kind_ff),
      .code    (alu_code),
      .pt      (alu_pt),
      .other   (alu_other),
      .bounds  (bounds),
      .clip_pt (clip_pt),
      .pt_code (pt_code)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign in_sx = req_tdata[7:0];
   assign in_sy = req_tdata[15:8];
   assign in_ex = req_tdata[23:16];
   assign in_ey = req_tdata[31:24];
   assign in_ox = req_tdata[47:32];
   assign in_oy = req_tdata[63:48];

   // ALU operand select
   always_comb begin
      if (state_ff == ST_CODE0) begin
         alu_pt    = p0_ff;
         alu_other = p1_ff;
         alu_code  = c0_ff;
      end else if (state_ff == ST_CODE1) begin
         alu_pt    = p1_ff;
         alu_other = p0_ff;
         alu_code  = c1_ff;
      end else if (sel_ff) begin
         alu_pt    = p1_ff;
         alu_other = p0_ff;
         alu_code  = c1_ff;
      end else begin
         alu_pt    = p0_ff;
         alu_other = p1_ff;
         alu_code  = c0_ff;
      end
   end

   // result fields, byte wrapped
   assign pen_y   = 8'd127 - (p0_ff.y[7:0] - bounds.bottom_bound[7:0]);
   assign pen_x   = p0_ff.x[7:0] - bounds.left_bound[7:0] - 8'd128;
   assign delta_y = p0_ff.y[7:0] - p1_ff.y[7:0];
   assign delta_x = p1_ff.x[7:0] - p0_ff.x[7:0];

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      sel_in       = sel_ff;
      kind_in      = kind_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      c0_in        = c0_ff;
      c1_in        = c1_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in = req_tuser;
               p0_in.x = coord_type'(in_ox) + coord_type'(in_sx);
               p0_in.y = coord_type'(in_oy) + coord_type'(in_sy);
               p1_in.x = coord_type'(in_ox) + coord_type'(in_ex);
               p1_in.y = coord_type'(in_oy) + coord_type'(in_ey);
               step_in = '0;
               sel_in  = 1'b0;
               state_in = (req_tuser == KIND_INVALID) ? ST_IDLE : ST_CODE0;
            end
         end
         ST_CODE0: begin
            c0_in    = pt_code;
            state_in = ST_CODE1;
         end
         ST_CODE1: begin
            c1_in    = pt_code;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if ((c0_ff | c1_ff) == '0) begin
               // trivially inside: hold here until the result slot frees
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {delta_x, delta_y, pen_x, pen_y};
                  state_in     = ST_IDLE;
               end
            end else if ((c0_ff & c1_ff) != '0) begin
               state_in = ST_IDLE;
            end else if (step_ff >= STEP_W'(MAX_CLIP_STEPS)) begin
               state_in = ST_IDLE;
            end else begin
               sel_in   = (c0_ff == '0);
               step_in  = step_ff + STEP_W'(1);
               state_in = ST_CLIP;
            end
         end
         ST_CLIP: begin
            if (sel_ff) begin
               p1_in = clip_pt;
            end else begin
               p0_in = clip_pt;
            end
            state_in = ST_RECODE;
         end
         ST_RECODE: begin
            if (sel_ff) begin
               c1_in = pt_code;
            end else begin
               c0_in = pt_code;
            end
            state_in = ST_TEST;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      p0_ff       <= p0_in;
      p1_ff       <= p1_in;
      c0_ff       <= c0_in;
      c1_ff       <= c1_in;
      rsp_data_ff <= rsp_data_in;
   end

   `ASSERT_HOLDS(a_step_limit, clock, reset, step_ff <= STEP_W'(MAX_CLIP_STEPS), "clip step count past limit")
   `ASSERT_NEVER(a_clip_inside_pt, clock, reset, (state_ff == ST_CLIP) && ((sel_ff ? c1_ff : c0_ff) == '0), "clipping a point that is inside")
   `ASSERT_NEVER(a_clip_shared_bit, clock, reset, (state_ff == ST_CLIP) && ((c0_ff & c1_ff) != '0), "clipping a segment that should be rejected")
   `ASSERT_NEVER(a_clip_bad_kind, clock, reset, (state_ff != ST_IDLE) && (kind_ff == KIND_INVALID), "invalid line kind entered the clip loop")
   `ASSERT_HOLDS(a_rsp_from_test, clock, reset, ($rose(rsp_tvalid)) |-> ($past(state_ff) == ST_TEST), "result loaded outside the test step")

endmodule
